/* rtl/sead_pkg.sv */
// Package with the payload types, command codes, sequencer states and the site mask function.
package sead_pkg;

   localparam int COUNT_W = 12;
   localparam int ID_W    = 10;
   localparam int CFG_W   = 24;
   localparam int DELTA_W = 35;
   localparam int AREA_W  = COUNT_W + 1;
   localparam int NUM_W   = CFG_W + AREA_W + 16;
   localparam int DEN_W   = CFG_W + 1;
   localparam int QUO_W   = 32;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_EVAL   = 2'd0,
      CMD_COMMIT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_E0   = 1'b0,
      REG_AREF = 1'b1
   } reg_index_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [7:0]        x_coord;
      logic [7:0]        y_coord;
      logic              new_present;
      logic [ID_W-1:0]   new_cell;
      logic              old_present;
      logic [ID_W-1:0]   old_cell;
   } req_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta_energy;
      logic                      at_site;
      logic [COUNT_W-1:0]        old_cell_sites;
      logic [COUNT_W-1:0]        new_cell_sites;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_NEW,
      ST_RD_WAIT,
      ST_WR_OLD,
      ST_WR_NEW,
      ST_TERM,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   function automatic logic on_mask(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] sum;
      logic       stem;
      logic       left;
      logic       right;
      sum   = {1'b0, x} + {1'b0, y};
      stem  = (y >= 8'd20) && (y <= 8'd100) && (x >= 8'd97) && (x <= 8'd103);
      left  = (y >= 8'd100) && (y <= 8'd160) && (sum >= 9'd197) && (sum <= 9'd203);
      right = (y >= 8'd100) && (y <= 8'd160) &&
              ({1'b0, x} <= {1'b0, y} + 9'd3) && ({1'b0, y} <= {1'b0, x} + 9'd3);
      return (x < 8'd200) && (y < 8'd200) && (stem || left || right);
   endfunction

endpackage

/* rtl/sead_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module sead_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/sead_div.sv */
// Restoring divider that retires two quotient bits per cycle.
module sead_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sead_pkg::NUM_W-1:0]   num,
   input  logic [sead_pkg::DEN_W-1:0]   den,
   output logic                         done,
   output logic [sead_pkg::QUO_W-1:0]   quo
);
   import sead_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [3:0]       cnt_ff;
   logic             run_ff;
   logic             done_ff;

   always_comb begin
      logic [DEN_W:0] t;
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      for (int i = 0; i < 2; i++) begin
         t      = {rem_in, low_in[QUO_W-1]};
         low_in = low_in << 1;
         if (t >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(t - {1'b0, den_ff});
            quo_in = {quo_in[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = t[DEN_W-1:0];
            quo_in = {quo_in[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(num[NUM_W-1:QUO_W]);
         low_ff <= num[QUO_W-1:0];
         quo_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* rtl/saturating_adhesion_energy_delta.sv */
// Top level: site count memory, command sequencer and energy accumulation.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   request  | start, busy          | req_data (sead_pkg::req_type)
//   result   | rsp_valid            | rsp_data (sead_pkg::rsp_type)
//   csr      | csr_we               | csr_index, csr_wdata
//
// A request is taken when start is high and busy is low; one result follows.
// Evaluate accumulates up to four energy terms, each nonzero term a multiply and a divide.
// Reset and the clear command sweep the count memory.
// The result strobe lasts one cycle and cannot be stalled.
module saturating_adhesion_energy_delta #(
   parameter int MAX_CELLS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sead_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output sead_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [sead_pkg::CFG_W-1:0]    csr_wdata
);
   import sead_pkg::*;

   localparam int AW = $clog2(MAX_CELLS);

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic               site_ff;
   logic [CFG_W-1:0]   e0_ff, aref_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               clr_resp_ff;
   logic [COUNT_W-1:0] cnt_old_ff, cnt_new_ff;
   logic [1:0]         term_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [CFG_W+AREA_W-1:0] prod_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [COUNT_W-1:0] ram_wdata, ram_rdata;
   logic               div_start, div_done;
   logic [QUO_W-1:0]   div_quo;
   logic               old_ok, new_ok, same_id;
   logic [COUNT_W-1:0] dec_old, inc_new, new_base;
   logic [AREA_W-1:0]  term_a;
   logic               term_en, term_go;
   logic               req_go;

   assign req_go  = start && (state_ff == ST_IDLE);
   assign old_ok  = 17'(req_ff.old_cell) < 17'(MAX_CELLS);
   assign new_ok  = 17'(req_ff.new_cell) < 17'(MAX_CELLS);
   assign same_id = req_ff.old_present && (req_ff.old_cell == req_ff.new_cell);
   assign dec_old = (cnt_old_ff == '0) ? '0 : cnt_old_ff - 1'b1;
   assign inc_new = !new_ok ? '0 :
                    (cnt_new_ff == COUNT_MAX) ? COUNT_MAX : cnt_new_ff + 1'b1;
   assign new_base = same_id ? dec_old : cnt_new_ff;

   always_comb begin
      term_a  = '0;
      term_en = 1'b0;
      unique case (term_ff)
         2'd0: begin
            term_a  = AREA_W'(cnt_old_ff);
            term_en = req_ff.old_present;
         end
         2'd1: begin
            term_a  = AREA_W'(cnt_old_ff) - 1'b1;
            term_en = req_ff.old_present && (cnt_old_ff != '0);
         end
         2'd2: begin
            term_a  = AREA_W'(cnt_new_ff);
            term_en = req_ff.new_present;
         end
         default: begin
            term_a  = AREA_W'(cnt_new_ff) + 1'b1;
            term_en = req_ff.new_present;
         end
      endcase
   end
   assign term_go = term_en && (term_a != '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(MAX_CELLS - 1)) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.cmd == CMD_CLEAR) ? ST_CLEAR : ST_RD_OLD;
            end
         end
         ST_RD_OLD:  state_in = ST_RD_NEW;
         ST_RD_NEW:  state_in = ST_RD_WAIT;
         ST_RD_WAIT: begin
            priority if (site_ff && req_ff.cmd == CMD_COMMIT) begin
               state_in = ST_WR_OLD;
            end else if (site_ff && req_ff.cmd == CMD_EVAL) begin
               state_in = ST_TERM;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WR_OLD: state_in = ST_WR_NEW;
         ST_WR_NEW: state_in = ST_RESP;
         ST_TERM: begin
            priority if (term_go) begin
               state_in = ST_MUL;
            end else if (term_ff == 2'd3) begin
               state_in = ST_RESP;
            end
         end
         ST_MUL:    state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (term_ff == 2'd3) ? ST_RESP : ST_TERM;
            end
         end
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = AW'(req_ff.old_cell);
      ram_wdata = dec_old;
      ram_raddr = AW'(req_ff.old_cell);
      div_start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         ST_RD_NEW: ram_raddr = AW'(req_ff.new_cell);
         ST_WR_OLD: ram_we    = req_ff.old_present && old_ok;
         ST_WR_NEW: begin
            ram_we    = req_ff.new_present && new_ok;
            ram_waddr = AW'(req_ff.new_cell);
            ram_wdata = inc_new;
         end
         ST_DIV_GO: div_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         e0_ff        <= CFG_W'(12800);
         aref_ff      <= CFG_W'(64000);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_RESP);
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end else begin
            clr_addr_ff <= '0;
         end
         if (req_go) begin
            clr_resp_ff <= 1'b1;
         end
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_E0:   e0_ff   <= csr_wdata;
               REG_AREF: aref_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            req_ff     <= req_data;
            site_ff    <= on_mask(req_data.x_coord, req_data.y_coord);
            cnt_old_ff <= '0;
            cnt_new_ff <= '0;
            term_ff    <= '0;
            delta_ff   <= '0;
         end
         ST_RD_NEW:  cnt_old_ff <= old_ok ? ram_rdata : '0;
         ST_RD_WAIT: cnt_new_ff <= new_ok ? ram_rdata : '0;
         ST_WR_OLD: begin
            cnt_old_ff <= dec_old;
            cnt_new_ff <= new_base;
         end
         ST_WR_NEW: begin
            if (req_ff.new_present) begin
               cnt_new_ff <= inc_new;
               if (same_id) begin
                  cnt_old_ff <= inc_new;
               end
            end
         end
         ST_TERM: begin
            if (!term_go) begin
               term_ff <= term_ff + 2'd1;
            end
            prod_ff <= e0_ff * term_a;
            den_ff  <= DEN_W'(aref_ff) + (DEN_W'(term_a) << 8);
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               term_ff <= term_ff + 2'd1;
               if (term_ff[0]) begin
                  delta_ff <= delta_ff - DELTA_W'(div_quo);
               end else begin
                  delta_ff <= delta_ff + DELTA_W'(div_quo);
               end
            end
         end
         ST_RESP: begin
            rsp_ff.delta_energy   <= delta_ff;
            rsp_ff.at_site        <= site_ff;
            rsp_ff.old_cell_sites <= req_ff.old_present ? cnt_old_ff : '0;
            rsp_ff.new_cell_sites <= req_ff.new_present ? cnt_new_ff : '0;
         end
         default: ;
      endcase
   end

   sead_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sead_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({prod_ff, 16'd0}),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

/* rtl/sead_check.sv */
// Port-level checker for the adhesion energy block and its bind statement.
module sead_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input sead_pkg::rsp_type rsp_data
);
   import sead_pkg::*;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request transfer");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_off_site: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.at_site) |-> (rsp_data.delta_energy == '0))
      else $error("nonzero energy change off the adhesive mask");
endmodule

bind saturating_adhesion_energy_delta sead_check u_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* bench/saturating_adhesion_energy_delta_test.sv */
// Self-checking testbench for the saturating adhesion energy delta block.
`timescale 1ns / 1ps

module saturating_adhesion_energy_delta_test;
   import sead_pkg::*;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_we;
   logic              csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   longint unsigned   model_e0;
   longint unsigned   model_aref;
   logic [COUNT_W-1:0] model_count [1024];
   rsp_type           pending_rsp [$];
   stim_row_type      directed_rows [$];
   int                error_count;
   int                idle_pct;

   saturating_adhesion_energy_delta dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int dist_abs(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic bit is_site(input logic [7:0] xc, input logic [7:0] yc);
      int x;
      int y;
      x = int'(xc);
      y = int'(yc);
      if (x >= 200 || y >= 200) return 1'b0;
      return (y >= 20 && y <= 100 && dist_abs(x, 100) <= 3) ||
             (y >= 100 && y <= 160 && dist_abs(x + y, 200) <= 3) ||
             (y >= 100 && y <= 160 && dist_abs(x, y) <= 3);
   endfunction

   function automatic longint energy_mag(input longint unsigned area);
      if (area == 0) return 0;
      return longint'(((model_e0 * area) << 16) / (model_aref + 256 * area));
   endfunction

   function automatic rsp_type predict_energy(input req_type r);
      rsp_type     res;
      bit          site;
      longint      delta;
      int unsigned a;
      site  = is_site(r.x_coord, r.y_coord);
      delta = 0;
      if (r.cmd == CMD_EVAL && site) begin
         if (r.old_present) begin
            a = 32'(model_count[r.old_cell]);
            if (a > 0) delta += energy_mag(a) - energy_mag(a - 1);
         end
         if (r.new_present) begin
            a = 32'(model_count[r.new_cell]);
            delta += energy_mag(a) - energy_mag(a + 1);
         end
      end else if (r.cmd == CMD_COMMIT && site) begin
         if (r.old_present && model_count[r.old_cell] != 0)
            model_count[r.old_cell] = model_count[r.old_cell] - 1'b1;
         if (r.new_present && model_count[r.new_cell] != COUNT_MAX)
            model_count[r.new_cell] = model_count[r.new_cell] + 1'b1;
      end else if (r.cmd == CMD_CLEAR) begin
         foreach (model_count[i]) model_count[i] = '0;
      end
      res.delta_energy   = delta[DELTA_W-1:0];
      res.at_site        = site;
      res.old_cell_sites = r.old_present ? model_count[r.old_cell] : '0;
      res.new_cell_sites = r.new_present ? model_count[r.new_cell] : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.delta_energy !== want.delta_energy)
               report_mismatch($sformatf("delta_energy %0d, want %0d",
                               rsp_data.delta_energy, want.delta_energy));
            if (rsp_data.at_site !== want.at_site)
               report_mismatch($sformatf("at_site %0b, want %0b",
                               rsp_data.at_site, want.at_site));
            if (rsp_data.old_cell_sites !== want.old_cell_sites)
               report_mismatch($sformatf("old_cell_sites %0d, want %0d",
                               rsp_data.old_cell_sites, want.old_cell_sites));
            if (rsp_data.new_cell_sites !== want.new_cell_sites)
               report_mismatch($sformatf("new_cell_sites %0d, want %0d",
                               rsp_data.new_cell_sites, want.new_cell_sites));
         end
      end
   end

   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      predicted = predict_energy(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic drain;
      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CFG_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == REG_E0) model_e0 = 64'(value);
      else model_aref = 64'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic req_type make_req(input cmd_type c, input int x, input int y,
                                        input bit np, input int nc, input bit op,
                                        input int oc);
      req_type r;
      r.cmd         = c;
      r.x_coord     = 8'(x);
      r.y_coord     = 8'(y);
      r.new_present = np;
      r.new_cell    = ID_W'(nc);
      r.old_present = op;
      r.old_cell    = ID_W'(oc);
      return r;
   endfunction

   task automatic add_row(input req_type r, input bit typed, input rsp_type rsp);
      stim_row_type row;
      row.req   = r;
      row.typed = typed;
      row.rsp   = rsp;
      directed_rows.push_back(row);
   endtask

   function automatic req_type random_req;
      req_type r;
      int      pick;
      int      y;
      r    = req_type'({$urandom, 8'($urandom)});
      pick = $urandom_range(99);
      if (pick < 85) begin
         case ($urandom_range(2))
            0: begin
               y = $urandom_range(20, 100);
               r.x_coord = 8'(97 + $urandom_range(6));
            end
            1: begin
               y = $urandom_range(100, 160);
               r.x_coord = 8'(197 - y + $urandom_range(6));
            end
            default: begin
               y = $urandom_range(100, 160);
               r.x_coord = 8'(y - 3 + $urandom_range(6));
            end
         endcase
         r.y_coord = 8'(y);
      end
      pick = $urandom_range(99);
      if (pick < 47) r.cmd = CMD_EVAL;
      else if (pick < 95) r.cmd = CMD_COMMIT;
      else if (pick < 98) r.cmd = CMD_CLEAR;
      else r.cmd = CMD_NONE;
      if ($urandom_range(99) < 80) begin
         r.new_cell = ID_W'($urandom_range(7));
         r.old_cell = ID_W'($urandom_range(7));
      end else if ($urandom_range(1)) begin
         r.new_cell = ID_W'(1016 + $urandom_range(7));
         r.old_cell = ID_W'(1016 + $urandom_range(7));
      end
      if ($urandom_range(99) < 10) r.old_cell = r.new_cell;
      return r;
   endfunction

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      rsp_type     zero_rsp;
      rsp_type     site_rsp;
      logic [CFG_W-1:0] e0_set [5];
      logic [CFG_W-1:0] aref_set [5];
      int          phase_idle [4];
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = REG_E0;
      csr_wdata   = '0;
      error_count = 0;
      idle_pct    = 0;
      model_e0    = 12800;
      model_aref  = 64000;
      foreach (model_count[i]) model_count[i] = '0;
      zero_rsp    = '0;
      site_rsp    = '0;
      site_rsp.at_site = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      add_row(make_req(CMD_EVAL, 255, 255, 1, 0, 1, 1), 1, zero_rsp);
      add_row(make_req(CMD_EVAL, 100, 20, 1, 0, 0, 0), 0, zero_rsp);
      add_row(make_req(CMD_COMMIT, 199, 199, 1, 5, 0, 0), 1, zero_rsp);
      add_row(make_req(CMD_COMMIT, 100, 50, 1, 5, 0, 0), 0, zero_rsp);
      add_row(make_req(CMD_COMMIT, 97, 100, 1, 5, 1, 9), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 103, 100, 1, 7, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 40, 160, 1, 5, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_COMMIT, 157, 160, 1, 5, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_COMMIT, 163, 160, 1, 1023, 1, 1022), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 100, 19, 1, 1023, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 96, 50, 1, 1023, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 160, 161, 1, 1023, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_EVAL, 100, 100, 1, 1023, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_NONE, 255, 0, 0, 0, 0, 0), 1, zero_rsp);
      add_row(make_req(CMD_NONE, 100, 60, 1, 5, 1, 5), 0, zero_rsp);
      add_row(make_req(CMD_CLEAR, 0, 0, 0, 1023, 0, 1023), 1, zero_rsp);
      add_row(make_req(CMD_EVAL, 100, 80, 0, 5, 1, 5), 1, site_rsp);
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      for (int i = 0; i < 40; i++)
         send_item(make_req(CMD_COMMIT, 100, 30, 1, 3, 1, 4), 0, zero_rsp);
      send_item(make_req(CMD_EVAL, 100, 30, 1, 3, 1, 3), 0, zero_rsp);
      send_item(make_req(CMD_COMMIT, 100, 30, 1, 3, 1, 3), 0, zero_rsp);
      drain();

      e0_set   = '{24'd12800, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd1000};
      aref_set = '{24'd64000, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd300};
      phase_idle = '{0, 79, 0, 19};
      for (int p = 0; p < 5; p++) begin
         write_csr(REG_E0, (p == 4) ? 24'($urandom) : e0_set[p]);
         write_csr(REG_AREF, (p == 4) ? 24'($urandom_range(1, 24'hFFFFFF)) : aref_set[p]);
         idle_pct = (p < 4) ? phase_idle[p] : 40;
         for (int i = 0; i < 255; i++) send_item(random_req(), 0, zero_rsp);
         drain();
      end

      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
